// File: hw/rtl/bsp_pkg.sv
`default_nettype none

package bsp_pkg;

	localparam int MAX_DEPTH_DEF = 32;

	localparam logic [7:0] CH_I     = 8'h69;
	localparam logic [7:0] CH_E     = 8'h65;
	localparam logic [7:0] CH_D     = 8'h64;
	localparam logic [7:0] CH_L     = 8'h6c;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;

	typedef enum logic [3:0] {
		PH_TOP      = 4'd0,
		PH_LVAL     = 4'd1,
		PH_DVAL     = 4'd2,
		PH_KEY      = 4'd3,
		PH_INTSTART = 4'd4,
		PH_INTDIG   = 4'd5,
		PH_LEN      = 4'd6,
		PH_KEYLEN   = 4'd7,
		PH_BODY     = 4'd8,
		PH_KEYBODY  = 4'd9
	} phase_t;

	typedef enum logic [1:0] {
		FIN_RUN  = 2'd0,
		FIN_DONE = 2'd1,
		FIN_ERR  = 2'd2
	} fin_t;

	typedef enum logic [1:0] {
		CT_LIST = 2'd1,
		CT_DICT = 2'd2
	} ctr_t;

	typedef enum logic [2:0] {
		EV_NONE     = 3'd0,
		EV_INT      = 3'd1,
		EV_STR_HDR  = 3'd2,
		EV_STR_BYTE = 3'd3,
		EV_LIST     = 3'd4,
		EV_DICT     = 3'd5,
		EV_CLOSE    = 3'd6
	} event_t;

	typedef enum logic [1:0] {
		ST_PROGRESS = 2'd0,
		ST_DONE     = 2'd1,
		ST_ERROR    = 2'd2,
		ST_IGNORED  = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       is_end;
		logic       restart;
	} item_t;

	typedef struct packed {
		logic [2:0]         event_kind;
		logic signed [63:0] value;
		logic [5:0]         depth;
		logic [1:0]         status;
	} result_t;

endpackage

`default_nettype wire

// File: hw/rtl/bsp_if.sv
`default_nettype none

interface bsp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       is_end;
	logic       restart;

	modport source (output valid, output data_byte, output is_end, output restart,
		input ready);
	modport sink (input valid, input data_byte, input is_end, input restart,
		output ready);
endinterface

interface bsp_out_if;
	logic               valid;
	logic               ready;
	logic [2:0]         event_kind;
	logic signed [63:0] value;
	logic [5:0]         depth;
	logic [1:0]         status;

	modport source (output valid, output event_kind, output value, output depth,
		output status, input ready);
	modport sink (input valid, input event_kind, input value, input depth,
		input status, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/bsp_core.sv
`default_nettype none

module bsp_core #(
	parameter int MAX_DEPTH = bsp_pkg::MAX_DEPTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             fire,
	input  wire bsp_pkg::item_t   item,
	output bsp_pkg::result_t      res
);

	localparam int DW = $clog2(MAX_DEPTH + 1);
	localparam int IW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

	bsp_pkg::phase_t ph_q, ph, ph_n;
	bsp_pkg::fin_t   fin_q, fin, fin_n;
	logic [DW-1:0]   d_q, d, d_n, d_sel, rd_addr;
	logic [63:0]     acc_q, acc, acc_n, acc10, digit;
	logic [63:0]     left_q, left, left_n;
	logic            neg_q, neg, neg_n;
	bsp_pkg::ctr_t   top_q, top_n, below_q, top_after, push_kind;
	bsp_pkg::ctr_t   mem [MAX_DEPTH];
	logic            push, pop, err, done_val, done_key, is_digit;
	bsp_pkg::event_t kind;
	logic [63:0]     val;
	bsp_pkg::status_t status;
	logic [7:0]      c;

	always_comb begin
		c = item.data_byte;
		ph = ph_q;
		d = d_q;
		acc = acc_q;
		neg = neg_q;
		left = left_q;
		fin = fin_q;
		if (item.restart) begin
			ph = bsp_pkg::PH_TOP;
			d = '0;
			acc = '0;
			neg = 1'b0;
			left = '0;
			fin = bsp_pkg::FIN_RUN;
		end
		ph_n = ph;
		d_n = d;
		acc_n = acc;
		neg_n = neg;
		left_n = left;
		fin_n = fin;
		kind = bsp_pkg::EV_NONE;
		val = '0;
		err = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		done_val = 1'b0;
		done_key = 1'b0;
		push_kind = bsp_pkg::CT_LIST;
		top_after = top_q;
		is_digit = (c >= bsp_pkg::CH_0) && (c <= bsp_pkg::CH_9);
		digit = 64'(c - bsp_pkg::CH_0);
		acc10 = (acc << 3) + (acc << 1) + digit;
		status = bsp_pkg::ST_PROGRESS;

		if (fin == bsp_pkg::FIN_DONE) begin
			status = bsp_pkg::ST_IGNORED;
		end else if (fin == bsp_pkg::FIN_ERR) begin
			status = bsp_pkg::ST_ERROR;
		end else if (item.is_end) begin
			fin_n = bsp_pkg::FIN_ERR;
		end else begin
			unique case (ph) inside
				bsp_pkg::PH_TOP, bsp_pkg::PH_LVAL, bsp_pkg::PH_DVAL: begin
					if (c == bsp_pkg::CH_I) begin
						acc_n = '0;
						neg_n = 1'b0;
						ph_n = bsp_pkg::PH_INTSTART;
					end else if (c == bsp_pkg::CH_L || c == bsp_pkg::CH_D) begin
						if (d >= DW'(MAX_DEPTH)) begin
							err = 1'b1;
						end else begin
							push = 1'b1;
							push_kind = (c == bsp_pkg::CH_L) ? bsp_pkg::CT_LIST
								: bsp_pkg::CT_DICT;
							d_n = d + DW'(1);
							kind = (c == bsp_pkg::CH_L) ? bsp_pkg::EV_LIST
								: bsp_pkg::EV_DICT;
							ph_n = (c == bsp_pkg::CH_L) ? bsp_pkg::PH_LVAL
								: bsp_pkg::PH_KEY;
						end
					end else if (is_digit) begin
						acc_n = digit;
						ph_n = bsp_pkg::PH_LEN;
					end else if (c == bsp_pkg::CH_E && ph == bsp_pkg::PH_LVAL) begin
						pop = 1'b1;
						d_n = d - DW'(1);
						kind = bsp_pkg::EV_CLOSE;
						done_val = 1'b1;
					end else begin
						err = 1'b1;
					end
				end
				bsp_pkg::PH_KEY: begin
					if (c == bsp_pkg::CH_E) begin
						pop = 1'b1;
						d_n = d - DW'(1);
						kind = bsp_pkg::EV_CLOSE;
						done_val = 1'b1;
					end else if (c == bsp_pkg::CH_COLON) begin
						acc_n = '0;
						kind = bsp_pkg::EV_STR_HDR;
						done_key = 1'b1;
					end else if (is_digit) begin
						acc_n = digit;
						ph_n = bsp_pkg::PH_KEYLEN;
					end else begin
						err = 1'b1;
					end
				end
				bsp_pkg::PH_INTSTART, bsp_pkg::PH_INTDIG: begin
					if (c == bsp_pkg::CH_MINUS && ph == bsp_pkg::PH_INTSTART) begin
						neg_n = 1'b1;
						ph_n = bsp_pkg::PH_INTDIG;
					end else if (c == bsp_pkg::CH_E) begin
						val = neg ? (64'd0 - acc) : acc;
						kind = bsp_pkg::EV_INT;
						done_val = 1'b1;
					end else if (is_digit) begin
						acc_n = acc10;
						ph_n = bsp_pkg::PH_INTDIG;
					end else begin
						err = 1'b1;
					end
				end
				bsp_pkg::PH_LEN, bsp_pkg::PH_KEYLEN: begin
					if (c == bsp_pkg::CH_COLON) begin
						val = acc;
						kind = bsp_pkg::EV_STR_HDR;
						if (acc == '0) begin
							done_val = (ph == bsp_pkg::PH_LEN);
							done_key = (ph == bsp_pkg::PH_KEYLEN);
						end else begin
							left_n = acc;
							ph_n = (ph == bsp_pkg::PH_KEYLEN) ? bsp_pkg::PH_KEYBODY
								: bsp_pkg::PH_BODY;
						end
					end else if (is_digit) begin
						acc_n = acc10;
					end else begin
						err = 1'b1;
					end
				end
				bsp_pkg::PH_BODY, bsp_pkg::PH_KEYBODY: begin
					kind = bsp_pkg::EV_STR_BYTE;
					val = {56'd0, c};
					left_n = left - 64'd1;
					if (left_n == '0) begin
						done_val = (ph == bsp_pkg::PH_BODY);
						done_key = (ph == bsp_pkg::PH_KEYBODY);
					end
				end
				default: begin
					err = 1'b1;
				end
			endcase

			top_after = pop ? below_q : top_q;
			if (done_key) begin
				ph_n = bsp_pkg::PH_DVAL;
			end else if (done_val) begin
				if (d_n == '0) begin
					fin_n = bsp_pkg::FIN_DONE;
					ph_n = bsp_pkg::PH_TOP;
				end else begin
					ph_n = (top_after == bsp_pkg::CT_DICT) ? bsp_pkg::PH_KEY
						: bsp_pkg::PH_LVAL;
				end
			end

			if (err) begin
				fin_n = bsp_pkg::FIN_ERR;
				kind = bsp_pkg::EV_NONE;
				val = '0;
			end

			unique case (fin_n)
				bsp_pkg::FIN_RUN:  status = bsp_pkg::ST_PROGRESS;
				bsp_pkg::FIN_DONE: status = bsp_pkg::ST_DONE;
				default:           status = bsp_pkg::ST_ERROR;
			endcase
		end
		if (fin == bsp_pkg::FIN_RUN && item.is_end) begin
			status = bsp_pkg::ST_ERROR;
		end

		top_n = push ? push_kind : (pop ? below_q : top_q);
		d_sel = fire ? d_n : d_q;
		rd_addr = d_sel - DW'(2);

		res.event_kind = kind;
		res.value = val;
		res.depth = 6'(d_n);
		res.status = status;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= bsp_pkg::PH_TOP;
			fin_q <= bsp_pkg::FIN_RUN;
			d_q <= '0;
			acc_q <= '0;
			neg_q <= 1'b0;
			left_q <= '0;
		end else if (fire) begin
			ph_q <= ph_n;
			fin_q <= fin_n;
			d_q <= d_n;
			acc_q <= acc_n;
			neg_q <= neg_n;
			left_q <= left_n;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			top_q <= top_n;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && push) begin
			mem[d[IW-1:0]] <= push_kind;
		end
		below_q <= mem[rd_addr[IW-1:0]];
	end

	assert property (@(posedge clk) disable iff (!arst_n) d_q <= DW'(MAX_DEPTH))
		else $error("stack depth beyond its limit");

	assert property (@(posedge clk) disable iff (!arst_n)
		fire && !item.restart && fin_q == bsp_pkg::FIN_ERR |->
		res.status == bsp_pkg::ST_ERROR && res.event_kind == bsp_pkg::EV_NONE)
		else $error("transaction after an error not reported as error");

	assert property (@(posedge clk) disable iff (!arst_n)
		fire && (res.event_kind == bsp_pkg::EV_LIST || res.event_kind == bsp_pkg::EV_DICT)
		|=> d_q != '0)
		else $error("open event without a stack entry");

	assert property (@(posedge clk) disable iff (!arst_n)
		(ph_q == bsp_pkg::PH_BODY || ph_q == bsp_pkg::PH_KEYBODY) |-> left_q != '0)
		else $error("string body with no bytes left");

endmodule

`default_nettype wire

// File: hw/rtl/bencode_stream_parser_top.sv
// Streaming bencode parser. The msg channel takes one byte of the encoded
// message per transaction, together with an end-of-buffer flag and a restart
// flag that clears the parser before the byte is handled. The evt channel
// returns exactly one event per input transaction, in order: the event kind,
// its value, the nesting depth after the byte and the parse status.
// A byte is captured in an input register and decoded from there once the
// output register can take its event; the parser state is then updated and
// the event written to the output register.
// One byte is accepted per cycle for as long as events are taken; the parser
// state is updated once for each byte that is decoded.
// The container stack lives in a small memory with a prefetched entry below
// the top, so closing a container needs no further read of the memory.
// Reset empties the stack and returns the parser to waiting for a top value;
// no clearing pass is needed. When the receiver stalls, the pending event is
// held in the output register, one further byte waits in the input register
// and msg.ready then falls until evt is taken.
`default_nettype none

module bencode_stream_parser_top #(
	parameter int MAX_DEPTH = bsp_pkg::MAX_DEPTH_DEF
) (
	input wire logic  clk,
	input wire logic  arst_n,
	bsp_in_if.sink    msg,
	bsp_out_if.source evt
);

	logic             valid_s1;
	bsp_pkg::item_t   item_s1;
	logic             advance, fire;
	logic             evt_valid_q;
	bsp_pkg::result_t res, res_q;

	assign advance = !evt_valid_q || evt.ready;
	assign fire = valid_s1 && advance;
	assign msg.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			evt_valid_q <= 1'b0;
		end else begin
			if (msg.ready) begin
				valid_s1 <= msg.valid;
			end
			if (advance) begin
				evt_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (msg.valid && msg.ready) begin
			item_s1 <= '{data_byte: msg.data_byte, is_end: msg.is_end,
				restart: msg.restart};
		end
		if (fire) begin
			res_q <= res;
		end
	end

	bsp_core #(
		.MAX_DEPTH(MAX_DEPTH)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.fire(fire),
		.item(item_s1),
		.res(res)
	);

	assign evt.valid = evt_valid_q;
	assign evt.event_kind = res_q.event_kind;
	assign evt.value = res_q.value;
	assign evt.depth = res_q.depth;
	assign evt.status = res_q.status;

endmodule

`default_nettype wire

// File: dv/tb.sv
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LONG_HOLD = 150;

	typedef struct {
		bsp_pkg::item_t it;
		bit             drain;
	} pending_byte_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic       in_valid = 1'b0;
	logic [7:0] in_byte = 8'h00;
	logic       in_end = 1'b0;
	logic       in_restart = 1'b0;
	logic       out_ready = 1'b0;

	bsp_in_if  msg_if();
	bsp_out_if evt_if();

	assign msg_if.valid     = in_valid;
	assign msg_if.data_byte = in_byte;
	assign msg_if.is_end    = in_end;
	assign msg_if.restart   = in_restart;
	assign evt_if.ready     = out_ready;

	bencode_stream_parser_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg_if),
		.evt    (evt_if)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Parser state as predicted from the accepted bytes.
	bsp_pkg::phase_t ph;
	bsp_pkg::ctr_t   cstack [bsp_pkg::MAX_DEPTH_DEF];
	int              sdepth;
	logic [63:0]     acc;
	bit              neg;
	logic [63:0]     left_bytes;
	bsp_pkg::fin_t   fin;

	pending_byte_t     bytes_to_send [$];
	bsp_pkg::result_t  events_due [$];
	logic [7:0]        msg_bytes [$];

	bit          in_taken = 1'b0;
	bit          out_taken = 1'b0;
	bit          tx_busy = 1'b1;
	bit          rx_busy = 1'b1;
	int unsigned gap = 0;
	int unsigned rx_left = 0;
	int          n_sent = 0;
	int          n_events = 0;
	int          n_fail = 0;
	int          n_done = 0;
	int          n_err = 0;
	int          n_ignored = 0;
	int          deepest = 0;

	function automatic void clear_parser();
		ph = bsp_pkg::PH_TOP;
		foreach (cstack[i])
			cstack[i] = bsp_pkg::CT_LIST;
		sdepth = 0;
		acc = '0;
		neg = 1'b0;
		left_bytes = '0;
		fin = bsp_pkg::FIN_RUN;
	endfunction

	function automatic bit is_digit(logic [7:0] c);
		return c >= bsp_pkg::CH_0 && c <= bsp_pkg::CH_9;
	endfunction

	function automatic void value_done(bit key);
		if (key) begin
			ph = bsp_pkg::PH_DVAL;
		end else if (sdepth == 0) begin
			fin = bsp_pkg::FIN_DONE;
			ph = bsp_pkg::PH_TOP;
		end else begin
			ph = (cstack[sdepth - 1] == bsp_pkg::CT_DICT) ? bsp_pkg::PH_KEY
				: bsp_pkg::PH_LVAL;
		end
	endfunction

	function automatic void open_body(bit key);
		if (acc == 0) begin
			value_done(key);
		end else begin
			left_bytes = acc;
			ph = key ? bsp_pkg::PH_KEYBODY : bsp_pkg::PH_BODY;
		end
	endfunction

	function automatic bsp_pkg::result_t parse_byte(bsp_pkg::item_t it);
		bsp_pkg::result_t r;
		logic [7:0]       c;
		bit               bad;
		r = '0;
		c = it.data_byte;
		bad = 1'b0;
		if (it.restart)
			clear_parser();
		if (fin == bsp_pkg::FIN_DONE) begin
			r.status = bsp_pkg::ST_IGNORED;
		end else if (fin == bsp_pkg::FIN_ERR) begin
			r.status = bsp_pkg::ST_ERROR;
		end else if (it.is_end) begin
			fin = bsp_pkg::FIN_ERR;
			r.status = bsp_pkg::ST_ERROR;
		end else begin
			case (ph)
				bsp_pkg::PH_TOP, bsp_pkg::PH_LVAL, bsp_pkg::PH_DVAL: begin
					if (c == bsp_pkg::CH_I) begin
						acc = '0;
						neg = 1'b0;
						ph = bsp_pkg::PH_INTSTART;
					end else if (c == bsp_pkg::CH_L || c == bsp_pkg::CH_D) begin
						if (sdepth >= bsp_pkg::MAX_DEPTH_DEF) begin
							bad = 1'b1;
						end else begin
							cstack[sdepth] = (c == bsp_pkg::CH_L) ? bsp_pkg::CT_LIST
								: bsp_pkg::CT_DICT;
							sdepth++;
							r.event_kind = (c == bsp_pkg::CH_L) ? bsp_pkg::EV_LIST
								: bsp_pkg::EV_DICT;
							ph = (c == bsp_pkg::CH_L) ? bsp_pkg::PH_LVAL
								: bsp_pkg::PH_KEY;
						end
					end else if (is_digit(c)) begin
						acc = {56'd0, c - bsp_pkg::CH_0};
						ph = bsp_pkg::PH_LEN;
					end else if (c == bsp_pkg::CH_E && ph == bsp_pkg::PH_LVAL) begin
						sdepth--;
						r.event_kind = bsp_pkg::EV_CLOSE;
						value_done(1'b0);
					end else begin
						bad = 1'b1;
					end
				end
				bsp_pkg::PH_KEY: begin
					if (c == bsp_pkg::CH_E) begin
						sdepth--;
						r.event_kind = bsp_pkg::EV_CLOSE;
						value_done(1'b0);
					end else if (c == bsp_pkg::CH_COLON) begin
						acc = '0;
						r.event_kind = bsp_pkg::EV_STR_HDR;
						open_body(1'b1);
					end else if (is_digit(c)) begin
						acc = {56'd0, c - bsp_pkg::CH_0};
						ph = bsp_pkg::PH_KEYLEN;
					end else begin
						bad = 1'b1;
					end
				end
				bsp_pkg::PH_INTSTART, bsp_pkg::PH_INTDIG: begin
					if (c == bsp_pkg::CH_MINUS && ph == bsp_pkg::PH_INTSTART) begin
						neg = 1'b1;
						ph = bsp_pkg::PH_INTDIG;
					end else if (c == bsp_pkg::CH_E) begin
						r.value = neg ? 64'd0 - acc : acc;
						r.event_kind = bsp_pkg::EV_INT;
						value_done(1'b0);
					end else if (is_digit(c)) begin
						acc = acc * 64'd10 + {56'd0, c - bsp_pkg::CH_0};
						ph = bsp_pkg::PH_INTDIG;
					end else begin
						bad = 1'b1;
					end
				end
				bsp_pkg::PH_LEN, bsp_pkg::PH_KEYLEN: begin
					if (c == bsp_pkg::CH_COLON) begin
						r.event_kind = bsp_pkg::EV_STR_HDR;
						r.value = acc;
						open_body(ph == bsp_pkg::PH_KEYLEN);
					end else if (is_digit(c)) begin
						acc = acc * 64'd10 + {56'd0, c - bsp_pkg::CH_0};
					end else begin
						bad = 1'b1;
					end
				end
				bsp_pkg::PH_BODY, bsp_pkg::PH_KEYBODY: begin
					r.event_kind = bsp_pkg::EV_STR_BYTE;
					r.value = {56'd0, c};
					left_bytes--;
					if (left_bytes == 0)
						value_done(ph == bsp_pkg::PH_KEYBODY);
				end
				default: begin
					bad = 1'b1;
				end
			endcase
			if (bad) begin
				fin = bsp_pkg::FIN_ERR;
				r.event_kind = bsp_pkg::EV_NONE;
				r.value = '0;
			end
			r.status = (fin == bsp_pkg::FIN_DONE) ? bsp_pkg::ST_DONE
				: (fin == bsp_pkg::FIN_ERR) ? bsp_pkg::ST_ERROR : bsp_pkg::ST_PROGRESS;
		end
		r.depth = 6'(sdepth);
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("Mismatch in %s at event %0d: got %0d, expected %0d", what, n_events,
			got, want);
		n_fail++;
	endtask

	// Outputs are checked before the byte taken at the same edge is predicted.
	always @(posedge clk) begin : scoreboard
		bsp_pkg::result_t want;
		bsp_pkg::item_t   it;
		bit               took_in;
		bit               took_out;
		took_in = 1'b0;
		took_out = 1'b0;
		if (arst_n && evt_if.valid && evt_if.ready) begin
			took_out = 1'b1;
			n_events <= n_events + 1;
			if (events_due.size() == 0) begin
				report_mismatch("event with none pending", longint'(evt_if.event_kind), 0);
			end else begin
				want = events_due.pop_front();
				if (evt_if.event_kind !== want.event_kind)
					report_mismatch("event_kind", longint'(evt_if.event_kind),
						longint'(want.event_kind));
				if (evt_if.value !== want.value)
					report_mismatch("value", evt_if.value, want.value);
				if (evt_if.depth !== want.depth)
					report_mismatch("depth", longint'(evt_if.depth), longint'(want.depth));
				if (evt_if.status !== want.status)
					report_mismatch("status", longint'(evt_if.status), longint'(want.status));
				if (want.status == bsp_pkg::ST_DONE)
					n_done <= n_done + 1;
				if (want.status == bsp_pkg::ST_ERROR)
					n_err <= n_err + 1;
				if (want.status == bsp_pkg::ST_IGNORED)
					n_ignored <= n_ignored + 1;
				if (int'(want.depth) > deepest)
					deepest <= int'(want.depth);
			end
		end
		if (arst_n && in_valid && msg_if.ready) begin
			took_in = 1'b1;
			it.data_byte = in_byte;
			it.is_end = in_end;
			it.restart = in_restart;
			events_due.push_back(parse_byte(it));
		end
		in_taken <= took_in;
		out_taken <= took_out;
	end

	always @(negedge clk) begin : driver
		pending_byte_t nx;
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap <= 0;
		end else if (!in_valid || in_taken) begin
			if (gap != 0) begin
				in_valid <= 1'b0;
				gap <= gap - 1;
			end else if (bytes_to_send.size() == 0 ||
				(bytes_to_send[0].drain && events_due.size() != 0)) begin
				in_valid <= 1'b0;
			end else begin
				nx = bytes_to_send.pop_front();
				in_byte <= nx.it.data_byte;
				in_end <= nx.it.is_end;
				in_restart <= nx.it.restart;
				in_valid <= 1'b1;
				gap <= tx_busy ? $urandom_range(0, 15) : 0;
				if ($urandom_range(0, 39) == 0)
					tx_busy <= !tx_busy;
				n_sent <= n_sent + 1;
			end
		end
	end

	always @(negedge clk) begin : receiver
		int unsigned hold;
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_left <= 0;
		end else begin
			hold = rx_left;
			if (out_taken) begin
				hold = rx_busy ? $urandom_range(0, 15) : 0;
				if (n_events == 250 || n_events == 800)
					hold = LONG_HOLD;
				if ($urandom_range(0, 39) == 0)
					rx_busy <= !rx_busy;
			end
			if (hold != 0) begin
				out_ready <= 1'b0;
				rx_left <= hold - 1;
			end else begin
				out_ready <= 1'b1;
				rx_left <= 0;
			end
		end
	end

	function automatic void put(logic [7:0] b, bit rs = 1'b0, bit en = 1'b0, bit dr = 1'b0);
		pending_byte_t p;
		p.it.data_byte = b;
		p.it.is_end = en;
		p.it.restart = rs;
		p.drain = dr;
		bytes_to_send.push_back(p);
	endfunction

	function automatic void put_text(string s);
		for (int i = 0; i < s.len(); i++)
			put(s[i], i == 0);
	endfunction

	function automatic logic [7:0] rand_digit();
		return bsp_pkg::CH_0 + 8'($urandom_range(0, 9));
	endfunction

	function automatic void emit_int();
		int n;
		msg_bytes.push_back(bsp_pkg::CH_I);
		if ($urandom_range(0, 2) == 0)
			msg_bytes.push_back(bsp_pkg::CH_MINUS);
		n = ($urandom_range(0, 5) == 0) ? $urandom_range(17, 24) : $urandom_range(0, 4);
		repeat (n)
			msg_bytes.push_back(rand_digit());
		msg_bytes.push_back(bsp_pkg::CH_E);
	endfunction

	function automatic void emit_str(bit key);
		int    n;
		string s;
		n = $urandom_range(0, 6);
		if (key && $urandom_range(0, 3) == 0) begin
			msg_bytes.push_back(bsp_pkg::CH_COLON);
		end else begin
			s = $sformatf("%0d", n);
			if ($urandom_range(0, 4) == 0)
				msg_bytes.push_back(bsp_pkg::CH_0);
			for (int i = 0; i < s.len(); i++)
				msg_bytes.push_back(s[i]);
			msg_bytes.push_back(bsp_pkg::CH_COLON);
			repeat (n)
				msg_bytes.push_back(8'($urandom_range(0, 255)));
		end
	endfunction

	// Builds one well-formed value, keeping open containers on a local stack.
	function automatic void emit_message();
		int left [$];
		bit is_dict [$];
		int k;
		bit complete;
		complete = 1'b0;
		while (!complete) begin
			k = $urandom_range(0, (left.size() < 4) ? 9 : 4);
			if (k <= 2) begin
				emit_int();
			end else if (k <= 4) begin
				emit_str(1'b0);
			end else begin
				msg_bytes.push_back((k <= 6) ? bsp_pkg::CH_L : bsp_pkg::CH_D);
				left.push_back($urandom_range(0, 3));
				is_dict.push_back(k > 6);
			end
			while (left.size() != 0 && left[left.size() - 1] == 0) begin
				msg_bytes.push_back(bsp_pkg::CH_E);
				void'(left.pop_back());
				void'(is_dict.pop_back());
			end
			if (left.size() == 0) begin
				complete = 1'b1;
			end else begin
				left[left.size() - 1] = left[left.size() - 1] - 1;
				if (is_dict[is_dict.size() - 1])
					emit_str(1'b1);
			end
		end
	endfunction

	initial begin : stimulus
		int sel;
		int idx;
		int n_rand;
		int msgs;
		bit add_end;
		bit rs;
		bit dr;
		clear_parser();
		n_rand = 0;
		msgs = 0;

		put_text("ie");
		put(8'h00, 1'b0, 1'b1);
		put_text("i-e");
		put(bsp_pkg::CH_E);
		put_text("ld:0:ee");
		put_text("i--");
		put_text("d1:ae");
		put(8'hff, 1'b1, 1'b1);
		put_text("e");
		put_text("3:");
		put(8'h00);
		put(8'hff);
		put(8'h5a, 1'b0, 1'b1);

		while (n_rand < 1150) begin
			msg_bytes.delete();
			add_end = 1'b0;
			sel = $urandom_range(0, 99);
			if (sel < 68) begin
				emit_message();
				add_end = ($urandom_range(0, 3) == 0);
			end else if (sel < 74) begin
				repeat (bsp_pkg::MAX_DEPTH_DEF)
					msg_bytes.push_back(bsp_pkg::CH_L);
				if ($urandom_range(0, 1) == 0)
					msg_bytes.push_back(($urandom_range(0, 1) == 0) ? bsp_pkg::CH_L
						: bsp_pkg::CH_D);
				else
					repeat (bsp_pkg::MAX_DEPTH_DEF)
						msg_bytes.push_back(bsp_pkg::CH_E);
			end else if (sel < 80) begin
				repeat ($urandom_range(19, 22))
					msg_bytes.push_back(rand_digit());
				msg_bytes.push_back(bsp_pkg::CH_COLON);
				repeat ($urandom_range(0, 4))
					msg_bytes.push_back(8'($urandom_range(0, 255)));
				add_end = 1'b1;
			end else if (sel < 92) begin
				emit_message();
				idx = $urandom_range(0, msg_bytes.size() - 1);
				case ($urandom_range(0, 2))
					0: msg_bytes[idx] = 8'($urandom_range(0, 255));
					1: begin
						while (msg_bytes.size() > idx)
							void'(msg_bytes.pop_back());
						add_end = 1'b1;
					end
					default: msg_bytes.insert(idx, 8'($urandom_range(0, 255)));
				endcase
			end else begin
				repeat ($urandom_range(1, 8)) begin
					put(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
						$urandom_range(0, 7) == 0);
					n_rand++;
				end
			end
			rs = ($urandom_range(0, 11) != 0);
			dr = (msgs % 15 == 0);
			foreach (msg_bytes[i])
				put(msg_bytes[i], rs && i == 0, 1'b0, dr && i == 0);
			if (add_end) begin
				put(8'($urandom_range(0, 255)), rs && msg_bytes.size() == 0, 1'b1,
					dr && msg_bytes.size() == 0);
				n_rand++;
			end
			n_rand += msg_bytes.size();
			if (sel < 68 && $urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 3)) begin
					put(8'($urandom_range(0, 255)));
					n_rand++;
				end
			msgs++;
		end

		wait (arst_n);
		while (bytes_to_send.size() != 0 || in_valid)
			@(negedge clk);
		while (events_due.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		$display("Sent %0d bytes in %0d messages and checked %0d events.", n_sent, msgs,
			n_events);
		$display("Completed %0d, error events %0d, ignored %0d, deepest nesting %0d.", n_done,
			n_err, n_ignored, deepest);
		if (n_fail == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin : watchdog
		#3000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire
